FILE: hw/rtl/sli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants of the sorted list block: operation and status
// codes, field widths and the control bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package sli_pkg;

   // default number of cells
   localparam int CAPACITY_DEF = 16;

   // field widths
   localparam int FUNC_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int RANK_W   = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int POS_W    = 4;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // operation codes
   typedef logic [FUNC_W-1:0] func_type;
   localparam func_type OP_INSERT = 2'd0;
   localparam func_type OP_DELETE = 2'd1;
   localparam func_type OP_READ   = 2'd2;

   // status codes
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_FULL     = 3'd1;
   localparam status_type ST_EMPTY    = 3'd2;
   localparam status_type ST_NOTFOUND = 3'd3;
   localparam status_type ST_RANK     = 3'd4;

   // command broadcast along the cell chain
   typedef struct packed {
      logic               ins;
      logic               del;
      logic [VALUE_W-1:0] value;
   } sli_cell_ctl_type;

endpackage

FILE: hw/rtl/sli_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted chain. Compares its entry against the broadcast
// value and, on insert or delete, keeps its entry or takes the new value or
// a neighbor's entry.
// ----------------------------------------------------------------------------
module sli_cell
   import sli_pkg::*;
(
   input  logic                 clock,
   input  sli_cell_ctl_type     ctl,
   input  logic                 occupied,
   input  logic                 left_le,
   input  logic [VALUE_W-1:0]   left_value,
   input  logic [VALUE_W-1:0]   right_value,
   output logic                 le,
   output logic                 lt,
   output logic                 eq,
   output logic [VALUE_W-1:0]   value
);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   // signed compares against the broadcast value
   assign le = occupied && ($signed(value_ff) <= $signed(ctl.value));
   assign lt = occupied && ($signed(value_ff) <  $signed(ctl.value));
   assign eq = occupied && (value_ff == ctl.value);
   assign value = value_ff;

   // insert opens a gap at the first cell above the value, delete closes
   // the gap from the first cell not below the value
   always_comb begin
      value_in = value_ff;
      if (ctl.ins && !le) begin
         if (left_le) begin
            value_in = ctl.value;
         end else begin
            value_in = left_value;
         end
      end else if (ctl.del && !lt) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: hw/rtl/sorted_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// The result of an item is registered and shown in the cycle after it is
// accepted. One item per cycle while results are taken; every cell compares
// and shifts in the same cycle, so each operation finishes in a single step.
// Reset (synchronous, active high) clears the entry count and result valid
// flag; cell contents stay undefined and are never read before written.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete
   import sli_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // item in: tdata = value[31:0], rank[35:32], zero pad[39:36]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser = func[1:0]
   input  logic [FUNC_W-1:0]     req_tuser,
   // item out: tdata = item_count[4:0], read_value[36:5], position[40:37],
   // zero pad[47:41]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tuser = status[2:0]
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   // request fields
   logic [VALUE_W-1:0] req_value;
   logic [RANK_W-1:0]  req_rank;
   logic               accept;

   assign req_value = req_tdata[VALUE_W-1:0];
   assign req_rank  = req_tdata[VALUE_W+RANK_W-1:VALUE_W];

   // control state
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff;
   logic [STATUS_W-1:0]   rsp_user_in;

   // chain wiring
   sli_cell_ctl_type     ctl;
   logic [CAPACITY-1:0]  le;
   logic [CAPACITY-1:0]  lt;
   logic [CAPACITY-1:0]  eq;
   logic [CAPACITY-1:0]  occupied;
   logic [CAPACITY-1:0]  ins_bnd;
   logic [CAPACITY-1:0]  del_first;
   logic [CAPACITY-1:0]  rd_hit;
   logic [VALUE_W-1:0]   cell_value [CAPACITY];

   logic                 full;
   logic                 found;
   logic                 rank_bad;
   logic [CMP_W-1:0]     rank_ext;
   logic [IDX_W-1:0]     ins_pos;
   logic [IDX_W-1:0]     del_pos;
   logic [VALUE_W-1:0]   rd_value;

   logic [STATUS_W-1:0]  status;
   logic [VALUE_W-1:0]   out_value;
   logic [IDX_W-1:0]     out_pos;
   logic [CNT_W+COUNT_W-1:0] count_wide;
   logic [IDX_W+POS_W-1:0]   pos_wide;

   // handshake: the result register frees up as it is taken, no item in reset
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign found    = |eq;
   assign rank_ext = CMP_W'(req_rank);
   assign rank_bad = (rank_ext >= CMP_W'(count_ff));

   // command to the cells
   always_comb begin
      ctl.value = req_value;
      ctl.ins   = accept && (req_tuser == OP_INSERT) && !full;
      ctl.del   = accept && (req_tuser == OP_DELETE) && found;
   end

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               left_le_w;
      logic [VALUE_W-1:0] left_value_w;
      logic [VALUE_W-1:0] right_value_w;

      assign occupied[i] = (count_ff > CNT_W'(i));
      assign rd_hit[i]   = (rank_ext == CMP_W'(i));

      if (i == 0) begin : g_first
         assign left_le_w    = 1'b1;
         assign left_value_w = req_value;
         assign del_first[i] = eq[i];
      end else begin : g_mid
         assign left_le_w    = le[i-1];
         assign left_value_w = cell_value[i-1];
         assign del_first[i] = eq[i] && !eq[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value_w = cell_value[i];
      end else begin : g_inner
         assign right_value_w = cell_value[i+1];
      end

      assign ins_bnd[i] = !le[i] && left_le_w;

      sli_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occupied[i]),
         .left_le     (left_le_w),
         .left_value  (left_value_w),
         .right_value (right_value_w),
         .le          (le[i]),
         .lt          (lt[i]),
         .eq          (eq[i]),
         .value       (cell_value[i])
      );
   end

   // encode the one-hot boundaries and select the read entry
   always_comb begin
      ins_pos  = '0;
      del_pos  = '0;
      rd_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ins_bnd[i]) begin
            ins_pos = ins_pos | IDX_W'(i);
         end
         if (del_first[i]) begin
            del_pos = del_pos | IDX_W'(i);
         end
         if (rd_hit[i]) begin
            rd_value = rd_value | cell_value[i];
         end
      end
   end

   // result and next count
   always_comb begin
      status    = ST_OK;
      out_value = '0;
      out_pos   = '0;
      count_in  = count_ff;
      case (req_tuser)
         OP_INSERT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               out_pos  = ins_pos;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (!found) begin
               status = ST_NOTFOUND;
            end else begin
               out_pos  = del_pos;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (rank_bad) begin
               status = ST_RANK;
            end else begin
               out_value = rd_value;
               out_pos   = IDX_W'(req_rank);
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   // fields masked to their output widths
   assign count_wide  = (CNT_W + COUNT_W)'(count_in);
   assign pos_wide    = (IDX_W + POS_W)'(out_pos);
   assign rsp_data_in = RSP_DATA_W'({pos_wide[POS_W-1:0], out_value,
                                     count_wide[COUNT_W-1:0]});
   assign rsp_user_in = status;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef ASSERT_OFF
   // the count never passes the number of cells
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // a sorted chain has at most one insert boundary
   a_ins_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ins_bnd))
      else $error("more than one insert boundary");

   // equal entries are contiguous, so one first match at most
   a_del_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(del_first))
      else $error("more than one first match on delete");

   // an insert that is not dropped grows the count by one
   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == OP_INSERT) && !full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the count");

   // a failed operation reports position zero
   a_err_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata[40:37] == '0)
      else $error("nonzero position on error");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_list_insert_delete. A short table of
// operations covers the empty, single-entry, extreme and out-of-range cases,
// then about 400 random operations run in fill, drain and mixed phases.
// Typed table rows carry their own expected result, other items are predicted
// by a software copy of the sorted table; the result stream is compared field
// by field, with random idling on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench
   import sli_pkg::*;
;

   localparam int CAPACITY    = CAPACITY_DEF;
   localparam int NUM_STEPS   = 23;
   localparam int NUM_RANDOM  = 400;
   localparam int PHASE_LEN   = 40;
   localparam int CALM_FROM   = 340;
   localparam int HOLD_AT     = 60;
   localparam int HOLD_CYCLES = 80;

   // opcode with no function, answered as a no-op
   localparam func_type OP_UNUSED = 2'd3;

   localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

   // fields of one result item
   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   count;
      logic [VALUE_W-1:0]   read_value;
      logic [POS_W-1:0]     position;
   } list_rsp_type;

   // one row of the directed table
   typedef struct packed {
      func_type             func;
      logic [VALUE_W-1:0]   value;
      logic [RANK_W-1:0]    rank;
      logic                 typed;
      list_rsp_type         rsp;
   } step_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   // software copy of the sorted table
   logic [VALUE_W-1:0] held_vals [CAPACITY];
   int                 held_count = 0;

   list_rsp_type pending_rsp [$];
   step_row_type steps [NUM_STEPS];
   int           error_count = 0;
   bit           calm = 1'b0;
   bit           hold_off_req = 1'b0;

   sorted_list_insert_delete #(
      .CAPACITY (CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit
   initial begin
      #200000;
      $display("testbench NOT OK");
      $finish;
   end

   // apply one operation to the table copy and return its result
   function automatic list_rsp_type apply_list_op(func_type op, logic [VALUE_W-1:0] val,
                                                  logic [RANK_W-1:0] rk);
      list_rsp_type r;
      int           at;
      int           k;
      bit           found;
      r = '0;
      at = 0;
      found = 1'b0;
      case (op)
         OP_INSERT: begin
            if (held_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               // new value goes after any equal ones
               while (at < held_count && $signed(held_vals[at]) <= $signed(val))
                  at++;
               for (k = held_count; k > at; k--)
                  held_vals[k] = held_vals[k-1];
               held_vals[at] = val;
               held_count++;
               r.position = at[POS_W-1:0];
            end
         end
         OP_DELETE: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               // first occurrence only
               for (k = 0; k < held_count && !found; k++) begin
                  if (held_vals[k] == val) begin
                     found = 1'b1;
                     at = k;
                  end
               end
               if (!found) begin
                  r.status = ST_NOTFOUND;
               end else begin
                  for (k = at; k + 1 < held_count; k++)
                     held_vals[k] = held_vals[k+1];
                  held_count--;
                  r.position = at[POS_W-1:0];
               end
            end
         end
         OP_READ: begin
            if (int'(rk) >= held_count) begin
               r.status = ST_RANK;
            end else begin
               r.read_value = held_vals[rk];
               r.position = rk;
            end
         end
         default: ;
      endcase
      r.count = held_count[COUNT_W-1:0];
      return r;
   endfunction

   function automatic step_row_type mk_row(func_type op, logic [VALUE_W-1:0] val,
                                           logic [RANK_W-1:0] rk, logic typed,
                                           status_type st, logic [COUNT_W-1:0] cnt,
                                           logic [VALUE_W-1:0] rdval,
                                           logic [POS_W-1:0] pos);
      step_row_type s;
      s.func = op;
      s.value = val;
      s.rank = rk;
      s.typed = typed;
      s.rsp.status = st;
      s.rsp.count = cnt;
      s.rsp.read_value = rdval;
      s.rsp.position = pos;
      return s;
   endfunction

   // offer one item, wait for acceptance, record its expected result
   task automatic send_item(func_type op, logic [VALUE_W-1:0] val, logic [RANK_W-1:0] rk,
                            logic typed, list_rsp_type typed_rsp);
      list_rsp_type predicted;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {{(REQ_DATA_W-VALUE_W-RANK_W){1'b0}}, rk, val};
      do @(posedge clock); while (!req_tready);
      predicted = apply_list_op(op, val, rk);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // value source: duplicates, held values, extremes or anything
   function automatic logic [VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel <= 3)
         return VALUE_W'($urandom_range(0, 7)) - 32'd4;
      else if (sel <= 5 && held_count > 0)
         return held_vals[$urandom_range(0, held_count - 1)];
      else if (sel == 6)
         case ($urandom_range(0, 3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return '1;
         endcase
      return $urandom;
   endfunction

   // item source
   initial begin
      int           n;
      int           roll;
      int           phase;
      func_type     op;
      logic [VALUE_W-1:0] val;
      logic [RANK_W-1:0]  rk;

      steps[0]  = mk_row(OP_DELETE, '0,           4'd0,  1'b1, ST_EMPTY,    5'd0, '0, 4'd0);
      steps[1]  = mk_row(OP_READ,   '0,           4'd0,  1'b1, ST_RANK,     5'd0, '0, 4'd0);
      steps[2]  = mk_row(OP_UNUSED, '1,           4'd15, 1'b1, ST_OK,       5'd0, '0, 4'd0);
      steps[3]  = mk_row(OP_INSERT, 32'd7,        4'd0,  1'b1, ST_OK,       5'd1, '0, 4'd0);
      // miss with a single entry held
      steps[4]  = mk_row(OP_DELETE, 32'd8,        4'd0,  1'b1, ST_NOTFOUND, 5'd1, '0, 4'd0);
      steps[5]  = mk_row(OP_DELETE, 32'd7,        4'd0,  1'b1, ST_OK,       5'd0, '0, 4'd0);
      steps[6]  = mk_row(OP_INSERT, VAL_MAX,      4'd0,  1'b1, ST_OK,       5'd1, '0, 4'd0);
      steps[7]  = mk_row(OP_INSERT, VAL_MIN,      4'd0,  1'b1, ST_OK,       5'd2, '0, 4'd0);
      steps[8]  = mk_row(OP_INSERT, '0,           4'd0,  1'b1, ST_OK,       5'd3, '0, 4'd1);
      steps[9]  = mk_row(OP_INSERT, '1,           4'd0,  1'b1, ST_OK,       5'd4, '0, 4'd1);
      // equal value lands after the one already held
      steps[10] = mk_row(OP_INSERT, '0,           4'd0,  1'b1, ST_OK,       5'd5, '0, 4'd3);
      steps[11] = mk_row(OP_READ,   '0,           4'd0,  1'b1, ST_OK,       5'd5, VAL_MIN,
                         4'd0);
      steps[12] = mk_row(OP_READ,   '0,           4'd4,  1'b1, ST_OK,       5'd5, VAL_MAX,
                         4'd4);
      steps[13] = mk_row(OP_READ,   '0,           4'd5,  1'b1, ST_RANK,     5'd5, '0, 4'd0);
      steps[14] = mk_row(OP_READ,   '1,           4'd15, 1'b1, ST_RANK,     5'd5, '0, 4'd0);
      steps[15] = mk_row(OP_DELETE, '0,           4'd0,  1'b1, ST_OK,       5'd4, '0, 4'd2);
      steps[16] = mk_row(OP_DELETE, VAL_MAX,      4'd0,  1'b1, ST_OK,       5'd3, '0, 4'd3);
      steps[17] = mk_row(OP_DELETE, VAL_MIN,      4'd0,  1'b1, ST_OK,       5'd2, '0, 4'd0);
      steps[18] = mk_row(OP_DELETE, 32'h5555_5555, 4'd0, 1'b1, ST_NOTFOUND, 5'd2, '0, 4'd0);
      steps[19] = mk_row(OP_INSERT, 32'haaaa_aaaa, 4'd0, 1'b0, ST_OK,       5'd0, '0, 4'd0);
      steps[20] = mk_row(OP_READ,   '0,           4'd1,  1'b0, ST_OK,       5'd0, '0, 4'd0);
      steps[21] = mk_row(OP_INSERT, 32'h5555_5555, 4'd0, 1'b0, ST_OK,       5'd0, '0, 4'd0);
      steps[22] = mk_row(OP_READ,   32'h1234_5678, 4'd3, 1'b0, ST_OK,       5'd0, '0, 4'd0);

      @(posedge clock);
      while (reset) @(posedge clock);

      // directed table
      for (n = 0; n < NUM_STEPS; n++)
         send_item(steps[n].func, steps[n].value, steps[n].rank, steps[n].typed,
                   steps[n].rsp);

      // random phases: fill, drain, mixed
      for (n = 0; n < NUM_RANDOM; n++) begin
         if (n == HOLD_AT)
            hold_off_req = 1'b1;
         if (n == CALM_FROM)
            calm = 1'b1;
         phase = (n / PHASE_LEN) % 3;
         roll = $urandom_range(0, 99);
         if (roll < 5)
            op = OP_UNUSED;
         else if (roll < 25)
            op = OP_READ;
         else if (phase == 0)
            op = (roll < 85) ? OP_INSERT : OP_DELETE;
         else if (phase == 1)
            op = (roll < 85) ? OP_DELETE : OP_INSERT;
         else
            op = (roll < 62) ? OP_INSERT : OP_DELETE;
         val = pick_value();
         if (op == OP_DELETE && phase == 1 && held_count > 0 && $urandom_range(0, 9) < 7)
            val = held_vals[$urandom_range(0, held_count - 1)];
         rk = RANK_W'($urandom);
         if (op == OP_READ && held_count > 0 && $urandom_range(0, 1) == 0)
            rk = RANK_W'($urandom_range(0, held_count - 1));
         send_item(op, val, rk, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      // drain and report
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // result receiver with random stalls and one long hold-off
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // result checker
   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.count = rsp_tdata[4:0];
         got.read_value = rsp_tdata[36:5];
         got.position = rsp_tdata[40:37];
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected item status=%0d count=%0d value=%h pos=%0d",
                     $time, got.status, got.count, got.read_value, got.position);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        got.status);
               error_count++;
            end
            if (got.count !== want.count) begin
               $display("%0t: item_count expected %0d actual %0d", $time, want.count,
                        got.count);
               error_count++;
            end
            if (got.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                        got.read_value);
               error_count++;
            end
            if (got.position !== want.position) begin
               $display("%0t: position expected %0d actual %0d", $time, want.position,
                        got.position);
               error_count++;
            end
         end
      end
   end

endmodule

FILE: sim.f
hw/rtl/sli_pkg.sv
hw/rtl/sli_cell.sv
hw/rtl/sorted_list_insert_delete.sv
test/testbench.sv
